// ----- rtl/core/evp_pkg.sv -----
// evp_pkg: shared types, widths and constants of the view projection pipeline
// holds the cordic lane type and the arctangent phase table
// no dependencies
package evp_pkg;

    localparam int ANGLE_ITER_DEF = 16;
    localparam int ATAN_ENTRIES   = 24;

    localparam int CORDIC_W = 34;
    localparam int LANES    = 4;
    localparam int LANE_PITCH = 0;
    localparam int LANE_YAW   = 1;
    localparam int LANE_ROLL  = 2;
    localparam int LANE_FOV   = 3;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam int COORD_W = 32;
    localparam int DELTA_W = COORD_W + 1;
    localparam int ROW_W   = 33;
    localparam int PROD_W  = DELTA_W + ROW_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int VIEW_W  = 40;
    localparam int SIN_W   = 31;
    localparam int CTR_W   = 12;
    localparam int FX_W    = CTR_W + SIN_W;
    localparam int FNUM_W  = FX_W + 16;
    localparam int FLO_W   = 30;
    localparam int MAG_W   = VIEW_W;
    localparam int NPROD_W = MAG_W + FNUM_W;
    localparam int OFFQ_W  = 31;
    localparam int PIX_W   = 13;
    localparam int QPIX_W  = 34;

    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [CORDIC_W-1:0] z;
        logic                       neg;
    } cordic_lane_t;

    function automatic logic [31:0] atan_phase(input int idx);
        logic [31:0] r;
        case (idx)
            0:  r = 32'd536870912;
            1:  r = 32'd316933406;
            2:  r = 32'd167458907;
            3:  r = 32'd85004756;
            4:  r = 32'd42667331;
            5:  r = 32'd21354465;
            6:  r = 32'd10679838;
            7:  r = 32'd5340245;
            8:  r = 32'd2670163;
            9:  r = 32'd1335087;
            10: r = 32'd667544;
            11: r = 32'd333772;
            12: r = 32'd166886;
            13: r = 32'd83443;
            14: r = 32'd41722;
            15: r = 32'd20861;
            16: r = 32'd10430;
            17: r = 32'd5215;
            18: r = 32'd2608;
            19: r = 32'd1304;
            20: r = 32'd652;
            21: r = 32'd326;
            22: r = 32'd163;
            23: r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/evp_cordic_cell.sv -----
// evp_cordic_cell: one rotation step of the sine/cosine cordic, four angles side by side
// depends on evp_pkg for the lane type and the arctangent table
// side data rides along unchanged
module evp_cordic_cell #(
    parameter int STEP   = 0,
    parameter int SIDE_W = 99
) (
    input  logic                                   aclk,
    input  logic                                   en,
    input  evp_pkg::cordic_lane_t [evp_pkg::LANES-1:0] lane_i,
    input  logic [SIDE_W-1:0]                      side_i,
    output evp_pkg::cordic_lane_t [evp_pkg::LANES-1:0] lane_o,
    output logic [SIDE_W-1:0]                      side_o
);
    import evp_pkg::*;

    localparam logic signed [CORDIC_W-1:0] ATAN_STEP =
        CORDIC_W'($signed({2'b00, atan_phase(STEP)}));

    cordic_lane_t [LANES-1:0] lane_next;
    cordic_lane_t [LANES-1:0] lane_reg;
    logic [SIDE_W-1:0]        side_reg;

    always_comb begin
        lane_next = lane_i;
        for (int l = 0; l < LANES; l++) begin
            if (lane_i[l].z >= 0) begin
                lane_next[l].x = lane_i[l].x - (lane_i[l].y >>> STEP);
                lane_next[l].y = lane_i[l].y + (lane_i[l].x >>> STEP);
                lane_next[l].z = lane_i[l].z - ATAN_STEP;
            end else begin
                lane_next[l].x = lane_i[l].x + (lane_i[l].y >>> STEP);
                lane_next[l].y = lane_i[l].y - (lane_i[l].x >>> STEP);
                lane_next[l].z = lane_i[l].z + ATAN_STEP;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
            side_reg <= side_i;
        end
    end

    assign lane_o = lane_reg;
    assign side_o = side_reg;

endmodule

// ----- rtl/core/evp_div_cell.sv -----
// evp_div_cell: one restoring division step, one quotient bit per cell
// no package dependencies; divisor, numerator and side data ride along
module evp_div_cell #(
    parameter int NUM_W   = 59,
    parameter int DEN_W   = 31,
    parameter int Q_W     = 59,
    parameter int SIDE_W  = 1,
    parameter int BIT_IDX = 0
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [DEN_W-1:0]  rem_i,
    input  logic [NUM_W-1:0]  num_i,
    input  logic [DEN_W-1:0]  den_i,
    input  logic [Q_W-1:0]    quo_i,
    input  logic [SIDE_W-1:0] side_i,
    output logic [DEN_W-1:0]  rem_o,
    output logic [NUM_W-1:0]  num_o,
    output logic [DEN_W-1:0]  den_o,
    output logic [Q_W-1:0]    quo_o,
    output logic [SIDE_W-1:0] side_o
);

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   diff;
    logic             take;
    logic [DEN_W-1:0] rem_next;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [Q_W-1:0]   quo_reg;
    logic [SIDE_W-1:0] side_reg;

    always_comb begin
        rem_sh   = {rem_i, num_i[NUM_W-1-BIT_IDX]};
        diff     = rem_sh - {1'b0, den_i};
        take     = (rem_sh >= {1'b0, den_i});
        rem_next = take ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            num_reg  <= num_i;
            den_reg  <= den_i;
            quo_reg  <= {quo_i[Q_W-2:0], take};
            side_reg <= side_i;
        end
    end

    assign rem_o  = rem_reg;
    assign num_o  = num_reg;
    assign den_o  = den_reg;
    assign quo_o  = quo_reg;
    assign side_o = side_reg;

endmodule

// ----- rtl/core/euler_view_projection.sv -----
// euler_view_projection: world-to-screen perspective projection, fully pipelined
// depends on evp_pkg, evp_cordic_cell and evp_div_cell
// cordic cells, matrix and dot product stages, focal and offset divider chains
//
// Takes one transaction per clock and gives one result per clock while the output
// moves. An accepted input reaches the output register through ANGLE_ITERATIONS
// cordic cells, five registers for trig fix-up, rotation matrix and dot products,
// 59 cells of the focal-length divider (one quotient bit each), three registers for
// the offset product and overflow check, 31 cells of each offset divider and the
// output register. The whole pipeline holds while a result waits on the output and
// m_tready is low. Write screen_width and screen_height via the cfg port only while
// the pipeline is empty, which the block does not check; cfg_ready is always high.
module euler_view_projection #(
    parameter int ANGLE_ITERATIONS = evp_pkg::ANGLE_ITER_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cam_x, cam_y, cam_z, cam_pitch, cam_yaw, cam_roll,
    // target_x, target_y, target_z, view_angle, zero pad
    input  logic [255:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // screen_x, screen_y, zero pad
    output logic [31:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [evp_pkg::PIX_W-1:0] cfg_data
);
    import evp_pkg::*;

    localparam int ITER    = ANGLE_ITERATIONS;
    localparam int SIDE_W  = 3 * DELTA_W;
    localparam int FSIDE_W = 3 * VIEW_W;
    localparam int LAT     = ITER + 5 + FNUM_W + 3 + OFFQ_W;
    localparam int ST_D2   = ITER + 4;

    // configuration
    logic [PIX_W-1:0] width_reg;
    logic [PIX_W-1:0] height_reg;
    logic [CTR_W-1:0] cx;
    logic [CTR_W-1:0] cy;

    assign cfg_ready = 1'b1;
    assign cx = width_reg[PIX_W-1:1];
    assign cy = height_reg[PIX_W-1:1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 13'd1920;
            height_reg <= 13'd1080;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic           adv;
    logic [LAT-1:0] vld_reg;
    logic           m_tvalid_reg;
    logic [31:0]    m_tdata_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg      <= {vld_reg[LAT-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[LAT-1];
        end
    end

    function automatic cordic_lane_t fold_phase(input logic [31:0] ph);
        logic signed [CORDIC_W-1:0] z;
        cordic_lane_t l;
        z = CORDIC_W'($signed(ph));
        l.neg = 1'b0;
        if (z > 34'sd1073741824) begin
            z = z - 34'sd2147483648;
            l.neg = 1'b1;
        end else if (z < -34'sd1073741824) begin
            z = z + 34'sd2147483648;
            l.neg = 1'b1;
        end
        l.x = CORDIC_GAIN;
        l.y = '0;
        l.z = z;
        return l;
    endfunction

    function automatic logic signed [CORDIC_W-1:0] qmul(
        input logic signed [CORDIC_W-1:0] a,
        input logic signed [CORDIC_W-1:0] b
    );
        logic signed [2*CORDIC_W-1:0] p;
        p = (2*CORDIC_W)'(a) * (2*CORDIC_W)'(b);
        return p[CORDIC_W+29:30];
    endfunction

    function automatic logic [PIX_W-1:0] clamp_pixel(
        input logic signed [QPIX_W-1:0] q,
        input logic [PIX_W-1:0]         lim
    );
        logic [PIX_W-1:0] r;
        if (q < 0)
            r = '0;
        else if (q > $signed({5'b00000, lim, 16'h0000}))
            r = lim;
        else
            r = q[28:16];
        return r;
    endfunction

    // input unpack, fold of angles and position deltas
    logic [14:0]                fov;
    cordic_lane_t [LANES-1:0]   lane_c [0:ITER];
    logic [SIDE_W-1:0]          side_c [0:ITER];
    logic signed [DELTA_W-1:0]  dx_in, dy_in, dz_in;

    always_comb begin
        fov = (s_tdata[254:240] == 15'd0) ? 15'd1 : s_tdata[254:240];
        lane_c[0][LANE_PITCH] = fold_phase({s_tdata[111:96], 16'h0000});
        lane_c[0][LANE_YAW]   = fold_phase({s_tdata[127:112], 16'h0000});
        lane_c[0][LANE_ROLL]  = fold_phase({s_tdata[143:128], 16'h0000});
        lane_c[0][LANE_FOV]   = fold_phase({2'b00, fov, 15'h0000});
        dx_in = $signed({s_tdata[175], s_tdata[175:144]}) - $signed({s_tdata[31], s_tdata[31:0]});
        dy_in = $signed({s_tdata[207], s_tdata[207:176]}) - $signed({s_tdata[63], s_tdata[63:32]});
        dz_in = $signed({s_tdata[239], s_tdata[239:208]}) - $signed({s_tdata[95], s_tdata[95:64]});
        side_c[0] = {dz_in, dy_in, dx_in};
    end

    genvar k;
    generate
        for (k = 0; k < ITER; k++) begin : g_cordic
            evp_cordic_cell #(
                .STEP   (k),
                .SIDE_W (SIDE_W)
            ) u_cell (
                .aclk   (aclk),
                .en     (adv),
                .lane_i (lane_c[k]),
                .side_i (side_c[k]),
                .lane_o (lane_c[k+1]),
                .side_o (side_c[k+1])
            );
        end
    endgenerate

    // trig fix-up
    logic signed [CORDIC_W-1:0] sp_reg, cp_reg, sy_reg, cy_reg, sr_reg, cr_reg;
    logic [SIN_W-1:0]           sh_reg, ch_reg;
    logic [SIDE_W-1:0]          dt_reg;
    cordic_lane_t [LANES-1:0]   lend;
    logic signed [CORDIC_W-1:0] sh_s, ch_s;
    logic [SIN_W-1:0]           sh_next, ch_next;

    always_comb begin
        lend    = lane_c[ITER];
        sh_s    = lend[LANE_FOV].neg ? -lend[LANE_FOV].y : lend[LANE_FOV].y;
        ch_s    = lend[LANE_FOV].neg ? -lend[LANE_FOV].x : lend[LANE_FOV].x;
        sh_next = (sh_s < 1) ? SIN_W'(1) : sh_s[SIN_W-1:0];
        ch_next = (ch_s < 0) ? '0 : ch_s[SIN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sp_reg <= lend[LANE_PITCH].neg ? -lend[LANE_PITCH].y : lend[LANE_PITCH].y;
            cp_reg <= lend[LANE_PITCH].neg ? -lend[LANE_PITCH].x : lend[LANE_PITCH].x;
            sy_reg <= lend[LANE_YAW].neg ? -lend[LANE_YAW].y : lend[LANE_YAW].y;
            cy_reg <= lend[LANE_YAW].neg ? -lend[LANE_YAW].x : lend[LANE_YAW].x;
            sr_reg <= lend[LANE_ROLL].neg ? -lend[LANE_ROLL].y : lend[LANE_ROLL].y;
            cr_reg <= lend[LANE_ROLL].neg ? -lend[LANE_ROLL].x : lend[LANE_ROLL].x;
            sh_reg <= sh_next;
            ch_reg <= ch_next;
            dt_reg <= side_c[ITER];
        end
    end

    // first products of the rotation matrix, focal numerator
    logic signed [CORDIC_W-1:0] cpcy_reg, cpsy_reg, srsp_reg, crsp_reg, crsy_reg;
    logic signed [CORDIC_W-1:0] crcy_reg, srcp_reg, srsy_reg, cysr_reg, crcp_reg;
    logic signed [CORDIC_W-1:0] sp1_reg, cy1_reg, sy1_reg;
    logic [FX_W-1:0]            fx1_reg;
    logic [SIN_W-1:0]           sh1_reg;
    logic [SIDE_W-1:0]          dt1_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            cpcy_reg <= qmul(cp_reg, cy_reg);
            cpsy_reg <= qmul(cp_reg, sy_reg);
            srsp_reg <= qmul(sr_reg, sp_reg);
            crsp_reg <= qmul(cr_reg, sp_reg);
            crsy_reg <= qmul(cr_reg, sy_reg);
            crcy_reg <= qmul(cr_reg, cy_reg);
            srcp_reg <= qmul(sr_reg, cp_reg);
            srsy_reg <= qmul(sr_reg, sy_reg);
            cysr_reg <= qmul(cy_reg, sr_reg);
            crcp_reg <= qmul(cr_reg, cp_reg);
            sp1_reg  <= sp_reg;
            cy1_reg  <= cy_reg;
            sy1_reg  <= sy_reg;
            fx1_reg  <= FX_W'(cx) * FX_W'(ch_reg);
            sh1_reg  <= sh_reg;
            dt1_reg  <= dt_reg;
        end
    end

    // matrix rows in Q28: index 0 right, 1 up, 2 depth
    logic signed [CORDIC_W:0]   rsum [3][3];
    logic signed [ROW_W-1:0]    m_reg [3][3];
    logic [FX_W-1:0]            fx2_reg;
    logic [SIN_W-1:0]           sh2_reg;
    logic [SIDE_W-1:0]          dt2_reg;

    always_comb begin
        rsum[2][0] = 35'(cpcy_reg);
        rsum[2][1] = 35'(cpsy_reg);
        rsum[2][2] = 35'(sp1_reg);
        rsum[0][0] = 35'(qmul(srsp_reg, cy1_reg)) - 35'(crsy_reg);
        rsum[0][1] = 35'(qmul(srsp_reg, sy1_reg)) + 35'(crcy_reg);
        rsum[0][2] = -35'(srcp_reg);
        rsum[1][0] = -(35'(qmul(crsp_reg, cy1_reg)) + 35'(srsy_reg));
        rsum[1][1] = 35'(cysr_reg) - 35'(qmul(crsp_reg, sy1_reg));
        rsum[1][2] = 35'(crcp_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    m_reg[r][c] <= rsum[r][c][CORDIC_W:2];
            fx2_reg <= fx1_reg;
            sh2_reg <= sh1_reg;
            dt2_reg <= dt1_reg;
        end
    end

    // dot product terms
    logic signed [DELTA_W-1:0] dv [3];
    logic signed [PROD_W-1:0]  pr_reg [3][3];
    logic [FX_W-1:0]           fx3_reg;
    logic [SIN_W-1:0]          sh3_reg;

    always_comb begin
        for (int c = 0; c < 3; c++)
            dv[c] = dt2_reg[c*DELTA_W +: DELTA_W];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    pr_reg[r][c] <= PROD_W'(dv[c]) * PROD_W'(m_reg[r][c]);
            fx3_reg <= fx2_reg;
            sh3_reg <= sh2_reg;
        end
    end

    // view coordinates, depth floored at one world unit
    logic signed [ACC_W-1:0]  acc [3];
    logic signed [VIEW_W-1:0] vd_next;
    logic signed [VIEW_W-1:0] vr_reg, vu_reg, vd_reg;
    logic [FX_W-1:0]          fx4_reg;
    logic [SIN_W-1:0]         sh4_reg;

    always_comb begin
        for (int r = 0; r < 3; r++)
            acc[r] = ACC_W'(pr_reg[r][0]) + ACC_W'(pr_reg[r][1]) + ACC_W'(pr_reg[r][2]);
        vd_next = acc[2][ACC_W-1:28];
        if (vd_next < 40'sd16)
            vd_next = 40'sd16;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            vr_reg  <= acc[0][ACC_W-1:28];
            vu_reg  <= acc[1][ACC_W-1:28];
            vd_reg  <= vd_next;
            fx4_reg <= fx3_reg;
            sh4_reg <= sh3_reg;
        end
    end

    // focal length: cx * cos * 65536 / sin
    logic [SIN_W-1:0]   frem [0:FNUM_W];
    logic [FNUM_W-1:0]  fnum [0:FNUM_W];
    logic [SIN_W-1:0]   fden [0:FNUM_W];
    logic [FNUM_W-1:0]  fquo [0:FNUM_W];
    logic [FSIDE_W-1:0] fside [0:FNUM_W];

    assign frem[0]  = '0;
    assign fnum[0]  = {fx4_reg, 16'h0000};
    assign fden[0]  = sh4_reg;
    assign fquo[0]  = '0;
    assign fside[0] = {vd_reg, vu_reg, vr_reg};

    generate
        for (k = 0; k < FNUM_W; k++) begin : g_fdiv
            evp_div_cell #(
                .NUM_W   (FNUM_W),
                .DEN_W   (SIN_W),
                .Q_W     (FNUM_W),
                .SIDE_W  (FSIDE_W),
                .BIT_IDX (k)
            ) u_cell (
                .aclk   (aclk),
                .en     (adv),
                .rem_i  (frem[k]),
                .num_i  (fnum[k]),
                .den_i  (fden[k]),
                .quo_i  (fquo[k]),
                .side_i (fside[k]),
                .rem_o  (frem[k+1]),
                .num_o  (fnum[k+1]),
                .den_o  (fden[k+1]),
                .quo_o  (fquo[k+1]),
                .side_o (fside[k+1])
            );
        end
    endgenerate

    // offset numerators |v| * f in two partial products
    logic signed [VIEW_W-1:0] vr_f, vu_f, vd_f;
    logic [MAG_W-1:0]         magx, magy;
    logic [FNUM_W-1:0]        f_q;
    logic [MAG_W+FLO_W-1:0]   pxl_reg, pyl_reg;
    logic [NPROD_W-FLO_W-1:0] pxh_reg, pyh_reg;
    logic                     sgnx1_reg, sgny1_reg, sgnx2_reg, sgny2_reg;
    logic [MAG_W-1:0]         dep1_reg, dep2_reg;
    logic [NPROD_W-1:0]       nx_reg, ny_reg;

    always_comb begin
        vr_f = fside[FNUM_W][VIEW_W-1:0];
        vu_f = fside[FNUM_W][2*VIEW_W-1:VIEW_W];
        vd_f = fside[FNUM_W][3*VIEW_W-1:2*VIEW_W];
        f_q  = fquo[FNUM_W];
        magx = vr_f[VIEW_W-1] ? (~vr_f + 40'd1) : vr_f;
        magy = vu_f[VIEW_W-1] ? (~vu_f + 40'd1) : vu_f;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pxl_reg   <= (MAG_W+FLO_W)'(magx) * (MAG_W+FLO_W)'(f_q[FLO_W-1:0]);
            pxh_reg   <= (NPROD_W-FLO_W)'(magx) * (NPROD_W-FLO_W)'(f_q[FNUM_W-1:FLO_W]);
            pyl_reg   <= (MAG_W+FLO_W)'(magy) * (MAG_W+FLO_W)'(f_q[FLO_W-1:0]);
            pyh_reg   <= (NPROD_W-FLO_W)'(magy) * (NPROD_W-FLO_W)'(f_q[FNUM_W-1:FLO_W]);
            sgnx1_reg <= vr_f[VIEW_W-1];
            sgny1_reg <= vu_f[VIEW_W-1];
            dep1_reg  <= vd_f;
            nx_reg    <= NPROD_W'(pxl_reg) + {pxh_reg, {FLO_W{1'b0}}};
            ny_reg    <= NPROD_W'(pyl_reg) + {pyh_reg, {FLO_W{1'b0}}};
            sgnx2_reg <= sgnx1_reg;
            sgny2_reg <= sgny1_reg;
            dep2_reg  <= dep1_reg;
        end
    end

    // saturation check: quotient reaches 2^31 when the high part is not below depth
    logic [MAG_W-1:0]  orx [0:OFFQ_W];
    logic [MAG_W-1:0]  ory [0:OFFQ_W];
    logic [OFFQ_W-1:0] onx [0:OFFQ_W];
    logic [OFFQ_W-1:0] ony [0:OFFQ_W];
    logic [MAG_W-1:0]  odx [0:OFFQ_W];
    logic [MAG_W-1:0]  ody [0:OFFQ_W];
    logic [OFFQ_W-1:0] oqx [0:OFFQ_W];
    logic [OFFQ_W-1:0] oqy [0:OFFQ_W];
    logic [1:0]        osx [0:OFFQ_W];
    logic [1:0]        osy [0:OFFQ_W];
    logic [MAG_W-1:0]  rx3_reg, ry3_reg, dep3_reg;
    logic [OFFQ_W-1:0] nx3_reg, ny3_reg;
    logic              satx3_reg, saty3_reg, sgnx3_reg, sgny3_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            satx3_reg <= (nx_reg[NPROD_W-1:OFFQ_W] >= (NPROD_W-OFFQ_W)'(dep2_reg));
            saty3_reg <= (ny_reg[NPROD_W-1:OFFQ_W] >= (NPROD_W-OFFQ_W)'(dep2_reg));
            rx3_reg   <= nx_reg[OFFQ_W+MAG_W-1:OFFQ_W];
            ry3_reg   <= ny_reg[OFFQ_W+MAG_W-1:OFFQ_W];
            nx3_reg   <= nx_reg[OFFQ_W-1:0];
            ny3_reg   <= ny_reg[OFFQ_W-1:0];
            sgnx3_reg <= sgnx2_reg;
            sgny3_reg <= sgny2_reg;
            dep3_reg  <= dep2_reg;
        end
    end

    assign orx[0] = rx3_reg;
    assign ory[0] = ry3_reg;
    assign onx[0] = nx3_reg;
    assign ony[0] = ny3_reg;
    assign odx[0] = dep3_reg;
    assign ody[0] = dep3_reg;
    assign oqx[0] = '0;
    assign oqy[0] = '0;
    assign osx[0] = {sgnx3_reg, satx3_reg};
    assign osy[0] = {sgny3_reg, saty3_reg};

    generate
        for (k = 0; k < OFFQ_W; k++) begin : g_odiv
            evp_div_cell #(
                .NUM_W   (OFFQ_W),
                .DEN_W   (MAG_W),
                .Q_W     (OFFQ_W),
                .SIDE_W  (2),
                .BIT_IDX (k)
            ) u_cell_x (
                .aclk   (aclk),
                .en     (adv),
                .rem_i  (orx[k]),
                .num_i  (onx[k]),
                .den_i  (odx[k]),
                .quo_i  (oqx[k]),
                .side_i (osx[k]),
                .rem_o  (orx[k+1]),
                .num_o  (onx[k+1]),
                .den_o  (odx[k+1]),
                .quo_o  (oqx[k+1]),
                .side_o (osx[k+1])
            );
            evp_div_cell #(
                .NUM_W   (OFFQ_W),
                .DEN_W   (MAG_W),
                .Q_W     (OFFQ_W),
                .SIDE_W  (2),
                .BIT_IDX (k)
            ) u_cell_y (
                .aclk   (aclk),
                .en     (adv),
                .rem_i  (ory[k]),
                .num_i  (ony[k]),
                .den_i  (ody[k]),
                .quo_i  (oqy[k]),
                .side_i (osy[k]),
                .rem_o  (ory[k+1]),
                .num_o  (ony[k+1]),
                .den_o  (ody[k+1]),
                .quo_o  (oqy[k+1]),
                .side_o (osy[k+1])
            );
        end
    endgenerate

    // pixel position and clamp
    logic [31:0]               offx, offy;
    logic signed [QPIX_W-1:0]  soffx, soffy, xq, yq;
    logic [PIX_W-1:0]          px, py;

    always_comb begin
        offx  = osx[OFFQ_W][0] ? 32'h8000_0000 : {1'b0, oqx[OFFQ_W]};
        offy  = osy[OFFQ_W][0] ? 32'h8000_0000 : {1'b0, oqy[OFFQ_W]};
        soffx = osx[OFFQ_W][1] ? -$signed({2'b00, offx}) : $signed({2'b00, offx});
        soffy = osy[OFFQ_W][1] ? -$signed({2'b00, offy}) : $signed({2'b00, offy});
        xq    = $signed({6'b000000, cx, 16'h0000}) + soffx;
        yq    = $signed({6'b000000, cy, 16'h0000}) - soffy;
        px    = clamp_pixel(xq, width_reg);
        py    = clamp_pixel(yq, height_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv)
            m_tdata_reg <= {6'b000000, py, px};
    end

`ifndef SYNTHESIS
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted transaction did not enter the pipeline");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (vld_reg == $past(vld_reg)))
        else $error("pipeline moved while output was stalled");

    a_depth_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[ST_D2] |-> (vd_reg >= 40'sd16))
        else $error("view depth below one world unit");
`endif

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// testbench for euler_view_projection: streams camera/target items through the
// projection pipeline and checks every screen position against a local predictor
// depends on evp_pkg and the euler_view_projection rtl
module testbench;

    import evp_pkg::*;

    localparam int LATENCY    = ANGLE_ITER_DEF + 99;
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_LEN   = 400;
    localparam logic [63:0] FOCAL_MAX  = 64'h4000_0000_0000_0000;
    localparam logic [63:0] OFFSET_MAX = 64'h0000_0000_8000_0000;

    // packed so that cam_x lands in the lowest bits of tdata
    typedef struct packed {
        logic               pad;
        logic [14:0]        view_angle;
        logic signed [31:0] target_z;
        logic signed [31:0] target_y;
        logic signed [31:0] target_x;
        logic [15:0]        cam_roll;
        logic [15:0]        cam_yaw;
        logic [15:0]        cam_pitch;
        logic signed [31:0] cam_z;
        logic signed [31:0] cam_y;
        logic signed [31:0] cam_x;
    } view_item_t;

    typedef struct packed {
        logic [12:0] screen_y;
        logic [12:0] screen_x;
    } pixel_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [255:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = REG_SCREEN_WIDTH;
    logic [12:0]  cfg_data = '0;

    view_item_t pending_items[$];
    pixel_t     expected_pixels[$];
    view_item_t held_item;
    int unsigned width_reg = 1920;
    int unsigned height_reg = 1080;
    int errors = 0;
    int results_seen = 0;
    int burst_left = 0;
    int gap_left = 0;
    int idle_cycles = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int rdy_mode = 0;
    int rdy_count = 0;

    euler_view_projection uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------- predictor ----------------

    function automatic void cordic_sincos(input logic [31:0] phase,
                                          output longint s, output longint c);
        longint z, x, y, t;
        bit flip;
        z = longint'($signed(phase));
        x = 652032874;
        y = 0;
        flip = 1'b0;
        if (z > 64'sd1073741824) begin
            z -= 64'sd2147483648;
            flip = 1'b1;
        end else if (z < -64'sd1073741824) begin
            z += 64'sd2147483648;
            flip = 1'b1;
        end
        for (int i = 0; i < ANGLE_ITER_DEF && i < ATAN_ENTRIES; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z -= longint'(atan_phase(i));
            end else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z += longint'(atan_phase(i));
            end
            x = t;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        s = y;
        c = x;
    endfunction

    function automatic longint q30_mul(input longint a, input longint b);
        return (a * b) >>> 30;
    endfunction

    function automatic logic [63:0] scaled_ratio(input logic [63:0] a, input logic [63:0] b,
                                                 input logic [63:0] d, input logic [63:0] cap);
        logic [127:0] p, q;
        p = {64'd0, a} * {64'd0, b};
        if (p[127:64] >= d)
            return cap;
        q = p / {64'd0, d};
        return (q > {64'd0, cap}) ? cap : q[63:0];
    endfunction

    function automatic longint lateral_offset(input longint v, input logic [63:0] focal,
                                              input longint depth);
        longint mag, off;
        mag = (v < 0) ? -v : v;
        off = longint'(scaled_ratio(mag, focal, depth, OFFSET_MAX));
        return (v < 0) ? -off : off;
    endfunction

    function automatic logic [12:0] clamp_to_window(input longint q16, input int unsigned lim);
        if (q16 < 0)
            return 13'd0;
        if (q16 > (longint'(lim) <<< 16))
            return lim[12:0];
        return q16[28:16];
    endfunction

    function automatic pixel_t project_target(input view_item_t it);
        longint sp, cp, sy, cy, sr, cr, sh, ch;
        longint fwd[3], rgt[3], upv[3], d[3];
        longint vr, vu, vd, cxp, cyp;
        logic [14:0] fov;
        logic [63:0] focal;
        pixel_t r;
        cordic_sincos({it.cam_pitch, 16'd0}, sp, cp);
        cordic_sincos({it.cam_yaw, 16'd0}, sy, cy);
        cordic_sincos({it.cam_roll, 16'd0}, sr, cr);
        fwd[0] = q30_mul(cp, cy);
        fwd[1] = q30_mul(cp, sy);
        fwd[2] = sp;
        rgt[0] = q30_mul(q30_mul(sr, sp), cy) - q30_mul(cr, sy);
        rgt[1] = q30_mul(q30_mul(sr, sp), sy) + q30_mul(cr, cy);
        rgt[2] = -q30_mul(sr, cp);
        upv[0] = -(q30_mul(q30_mul(cr, sp), cy) + q30_mul(sr, sy));
        upv[1] = q30_mul(cy, sr) - q30_mul(q30_mul(cr, sp), sy);
        upv[2] = q30_mul(cr, cp);
        d[0] = longint'(it.target_x) - longint'(it.cam_x);
        d[1] = longint'(it.target_y) - longint'(it.cam_y);
        d[2] = longint'(it.target_z) - longint'(it.cam_z);
        vr = 0;
        vu = 0;
        vd = 0;
        for (int i = 0; i < 3; i++) begin
            vr += d[i] * (rgt[i] >>> 2);
            vu += d[i] * (upv[i] >>> 2);
            vd += d[i] * (fwd[i] >>> 2);
        end
        vr = vr >>> 28;
        vu = vu >>> 28;
        vd = vd >>> 28;
        // anything closer than one world unit, or behind, sits at one unit
        if (vd < 16)
            vd = 16;
        fov = (it.view_angle == 0) ? 15'd1 : it.view_angle;
        cordic_sincos({2'b00, fov, 15'd0}, sh, ch);
        if (sh < 1)
            sh = 1;
        if (ch < 0)
            ch = 0;
        cxp = longint'(width_reg / 2);
        cyp = longint'(height_reg / 2);
        focal = scaled_ratio(cxp * ch, 64'd65536, sh, FOCAL_MAX);
        r.screen_x = clamp_to_window((cxp <<< 16) + lateral_offset(vr, focal, vd), width_reg);
        r.screen_y = clamp_to_window((cyp <<< 16) - lateral_offset(vu, focal, vd), height_reg);
        return r;
    endfunction

    // ---------------- driver ----------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_pixels.push_back(project_target(held_item));
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    held_item = pending_items.pop_front();
                    s_tdata <= held_item;
                    s_tvalid <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        errors++;
        $display("mismatch at result %0d: %s expected %0d got %0d",
                 results_seen, what, exp_v, got_v);
    endtask

    always @(posedge aclk) begin
        pixel_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[25:0];
                if (expected_pixels.size() == 0) begin
                    report_mismatch("unexpected transaction, x", -1, int'(got.screen_x));
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.screen_x != want.screen_x)
                        report_mismatch("screen_x", int'(want.screen_x), int'(got.screen_x));
                    if (got.screen_y != want.screen_y)
                        report_mismatch("screen_y", int'(want.screen_y), int'(got.screen_y));
                end
                results_seen++;
            end
            // one long hold-off so the pipeline fills and backs up the input
            if (!hold_done && results_seen >= 200) begin
                hold_done <= 1'b1;
                hold_left = HOLD_LEN;
            end
            if (rdy_count == 0) begin
                rdy_mode = $urandom_range(0, 3);
                rdy_count = $urandom_range(20, 120);
            end else begin
                rdy_count--;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (rdy_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    2: m_tready <= ($urandom_range(0, 7) != 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------- stimulus ----------------

    function automatic view_item_t make_item(input int cx, input int cy, input int cz,
                                             input int p, input int yw, input int rl,
                                             input int tx, input int ty, input int tz,
                                             input int fv);
        view_item_t it;
        it.pad = 1'b0;
        it.cam_x = cx; it.cam_y = cy; it.cam_z = cz;
        it.cam_pitch = 16'(p); it.cam_yaw = 16'(yw); it.cam_roll = 16'(rl);
        it.target_x = tx; it.target_y = ty; it.target_z = tz;
        it.view_angle = 15'(fv);
        return it;
    endfunction

    function automatic int near_value(input int center, input int span);
        return center + int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic view_item_t random_item();
        view_item_t it;
        int span;
        if ($urandom_range(0, 4) == 0) begin
            // raw noise over every bit but the pad
            it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            it.pad = 1'b0;
        end else begin
            span = 1 << $urandom_range(6, 20);
            it.pad = 1'b0;
            it.cam_x = near_value(0, 1 << 24);
            it.cam_y = near_value(0, 1 << 24);
            it.cam_z = near_value(0, 1 << 24);
            it.target_x = it.cam_x + near_value(0, span);
            it.target_y = it.cam_y + near_value(0, span);
            it.target_z = it.cam_z + near_value(0, span);
            it.cam_pitch = 16'($urandom);
            it.cam_yaw = 16'($urandom);
            it.cam_roll = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom);
            it.view_angle = ($urandom_range(0, 1) == 0) ? 15'($urandom_range(8000, 24000))
                                                         : 15'($urandom_range(0, 32767));
        end
        return it;
    endfunction

    task automatic write_register(input logic [1:0] idx, input int unsigned val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[12:0];
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        if (idx == REG_SCREEN_WIDTH)
            width_reg = val & 13'h1FFF;
        else
            height_reg = val & 13'h1FFF;
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_tvalid || expected_pixels.size() > 0)
            @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    int unsigned widths[6]  = '{4096, 2, 1023, 3, 4096, 640};
    int unsigned heights[6] = '{4096, 2, 4095, 1081, 3, 480};

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset window, field extremes and the special cases
        pending_items.push_back(make_item(0, 0, 0, 0, 0, 0, 1600, 0, 0, 16384));
        pending_items.push_back(make_item(0, 0, 0, 0, 0, 0, 1600, 320, 160, 16384));
        // target behind the camera and straight on top of it
        pending_items.push_back(make_item(0, 0, 0, 0, 0, 0, -1600, 50, 50, 16384));
        pending_items.push_back(make_item(100, 100, 100, 0, 0, 0, 100, 100, 100, 16384));
        pending_items.push_back(make_item(0, 0, 0, 0, 0, 0, 8, 200, -200, 16384));
        // zero and widest field of view, narrowest legal one
        pending_items.push_back(make_item(0, 0, 0, 0, 0, 0, 1600, 16, 16, 0));
        pending_items.push_back(make_item(0, 0, 0, 0, 0, 0, 1600, 800, 800, 32767));
        pending_items.push_back(make_item(0, 0, 0, 0, 0, 0, 1600, 1, -1, 1));
        // quarter-turn angles on each axis, then half, three-quarter and near-full turns on all three
        pending_items.push_back(make_item(0, 0, 0, 16'h4000, 0, 0, 0, 0, 1600, 16384));
        pending_items.push_back(make_item(0, 0, 0, 0, 16'h4000, 0, 0, 1600, 0, 16384));
        pending_items.push_back(make_item(0, 0, 0, 0, 0, 16'h4000, 1600, 100, 30, 16384));
        pending_items.push_back(make_item(0, 0, 0, 16'h8000, 16'h8000, 16'h8000,
                                          -1600, 40, 40, 16384));
        pending_items.push_back(make_item(0, 0, 0, 16'hC000, 16'hC000, 16'hC000,
                                          300, 300, -1600, 12000));
        pending_items.push_back(make_item(0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                          1600, 5, 5, 20000));
        // full range coordinates and huge offsets that saturate
        pending_items.push_back(make_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0,
                                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16384));
        pending_items.push_back(make_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0,
                                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16384));
        pending_items.push_back(make_item(0, 0, 0, 0, 0, 0, 16, 32'h7FFF_FFFF,
                                          32'h8000_0000, 100));
        pending_items.push_back(make_item(-5, 7, -9, 16'h1234, 16'hABCD, 16'h5555,
                                          32'h7FFF_0000, -12345, 99999, 32767));
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            write_register(REG_SCREEN_WIDTH, widths[ph]);
            write_register(REG_SCREEN_HEIGHT, heights[ph]);
            repeat (270) pending_items.push_back(random_item());
            wait_drained();
        end

        if (errors == 0 && expected_pixels.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/evp_pkg.sv
rtl/core/evp_cordic_cell.sv
rtl/core/evp_div_cell.sv
rtl/core/euler_view_projection.sv
verif/testbench.sv
